FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL files of the unescaper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and the UTF-8 encoder of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Surrogate tags: top six bits of a 16-bit code unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_BODY   = 4'd1,
        PH_ESC    = 4'd2,
        PH_HEX1   = 4'd3,
        PH_NEEDBS = 4'd4,
        PH_NEEDU  = 4'd5,
        PH_HEX2   = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NO_OPEN   = 4'd1,
        ERR_UNTERM    = 4'd2,
        ERR_CTRL      = 4'd3,
        ERR_OPEN_ESC  = 4'd4,
        ERR_BAD_ESC   = 4'd5,
        ERR_TRUNC_HEX = 4'd6,
        ERR_BAD_HEX   = 4'd7,
        ERR_LONE_HIGH = 4'd8,
        ERR_BAD_LOW   = 4'd9,
        ERR_LONE_LOW  = 4'd10
    } err_t;

    // Classified input word as handed from front to back
    typedef struct packed {
        logic       eod;
        logic [7:0] byte_val;
        logic       is_quote;
        logic       is_bsl;
        logic       is_ctrl;
        logic       is_u;
        logic       hex_ok;
        logic [3:0] hex_digit;
        logic       esc_ok;
        logic [7:0] esc_byte;
    } tok_t;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
    } utf8_t;

    // Encode a code point as one to four UTF-8 bytes, first byte lowest
    function automatic utf8_t utf8_pack(input logic [20:0] cp);
        utf8_t r;
        if (cp < 21'h80) begin
            r.bytes = {24'h0, cp[7:0]};
            r.count = 3'd1;
        end
        else if (cp < 21'h800) begin
            r.bytes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            r.count = 3'd2;
        end
        else if (cp < SUPP_BASE) begin
            r.bytes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            r.count = 3'd3;
        end
        else begin
            r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
            r.count = 3'd4;
        end
        return r;
    endfunction

endpackage

FILE: sv/json_string_unescape_utf8.sv
// Path: an accepted word is stored in the queue, then decoded into the result register.
// Throughput: one input word per cycle while out_stall is low, one result word per input word.
// The rate is set by the escape state machine in the back end.
// While out_stall holds, the input stalls once the two-entry queue is full (three words held).
// Reset (rst_n low, asynchronous) empties the queue and the result register and
// returns the decoder to waiting for an opening quote.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string literal decoder: classifier front, queue, UTF-8 emitting back end.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_bytes,
    output logic [2:0]  out_count,
    output logic [1:0]  status,
    output logic [3:0]  error_code
);
    import jsu_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    tok_t push_tok;
    tok_t head_tok;

    // Classify incoming words
    jsu_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .push        (push),
        .push_tok    (push_tok),
        .q_full      (q_full)
    );

    // Decouple front and back
    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_tok (head_tok)
    );

    // Decode and emit results
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head_tok   (head_tok),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_bytes  (out_bytes),
        .out_count  (out_count),
        .status     (status),
        .error_code (error_code)
    );

endmodule

FILE: sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw input words and classifies each byte for the decode back end.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  logic           end_of_data,
    output logic           push,
    output jsu_pkg::tok_t  push_tok,
    input  logic           q_full
);
    import jsu_pkg::*;

    tok_t tok;

    // Hold the input side while the queue is full
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign push_tok = tok;

    // Classify the byte
    always_comb
    begin
        tok           = '0;
        tok.eod       = end_of_data;
        tok.byte_val  = in_byte;
        tok.is_quote  = (in_byte == CH_QUOTE);
        tok.is_bsl    = (in_byte == CH_BSL);
        tok.is_ctrl   = (in_byte < 8'h20);
        tok.is_u      = (in_byte == CH_U);
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            tok.hex_ok    = 1'b1;
            tok.hex_digit = in_byte[3:0];
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            tok.hex_ok    = 1'b1;
            tok.hex_digit = in_byte[3:0] + 4'd9;
        end
        // Single-character escapes
        tok.esc_ok = 1'b1;
        unique case (in_byte) inside
            CH_QUOTE, CH_BSL, CH_SLASH: tok.esc_byte = in_byte;
            CH_B:    tok.esc_byte = 8'h08;
            CH_F:    tok.esc_byte = 8'h0c;
            CH_N:    tok.esc_byte = 8'h0a;
            CH_R:    tok.esc_byte = 8'h0d;
            CH_T:    tok.esc_byte = 8'h09;
            default:
            begin
                tok.esc_ok   = 1'b0;
                tok.esc_byte = 8'h00;
            end
        endcase
    end

endmodule

FILE: sv/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of classified words between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jsu_pkg::tok_t  push_tok,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output jsu_pkg::tok_t  head_tok
);
    import jsu_pkg::*;

    tok_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_tok = mem[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store words
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_tok;
    end

    `ASSERT_NEVER(a_queue_count_bound, clk, rst_n, count_reg > QUEUE_CW'(QUEUE_DEPTH))

endmodule

FILE: sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Escape state machine, surrogate joining, UTF-8 packing and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  jsu_pkg::tok_t  head_tok,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    out_bytes,
    output logic [2:0]     out_count,
    output logic [1:0]     status,
    output logic [3:0]     error_code
);
    import jsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  high_reg, high_next;

    logic        out_valid_reg;
    logic [31:0] out_bytes_reg;
    logic [2:0]  out_count_reg;
    status_t     status_reg;
    err_t        err_reg;

    err_t        step_err;
    status_t     step_status;
    utf8_t       step_data;
    logic [15:0] accum_shift;
    logic        last_digit;
    logic [20:0] pair_cp;

    // Take the next word when the result register is free or being drained
    assign pop = q_valid && (!out_valid_reg || !out_stall);

    assign accum_shift = {accum_reg[11:0], head_tok.hex_digit};
    assign last_digit  = (digits_reg == 2'd3);
    assign pair_cp     = SUPP_BASE + {1'b0, high_reg, accum_shift[9:0]};

    // Result and data path for the word at the queue head
    always_comb
    begin
        step_err    = ERR_NONE;
        step_status = ST_BUSY;
        step_data   = '0;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        high_next   = high_reg;
        unique case (phase_reg) inside
            PH_BODY:
            begin
                if (head_tok.eod)
                    step_err = ERR_UNTERM;
                else if (head_tok.is_quote)
                    step_status = ST_DONE;
                else if (head_tok.is_ctrl)
                    step_err = ERR_CTRL;
                else if (!head_tok.is_bsl)
                begin
                    step_data.bytes = {24'h0, head_tok.byte_val};
                    step_data.count = 3'd1;
                end
            end
            PH_ESC:
            begin
                if (head_tok.eod)
                    step_err = ERR_OPEN_ESC;
                else if (head_tok.esc_ok)
                begin
                    step_data.bytes = {24'h0, head_tok.esc_byte};
                    step_data.count = 3'd1;
                end
                else if (head_tok.is_u)
                begin
                    accum_next  = '0;
                    digits_next = '0;
                end
                else
                    step_err = ERR_BAD_ESC;
            end
            PH_HEX1, PH_HEX2:
            begin
                if (head_tok.eod)
                    step_err = ERR_TRUNC_HEX;
                else if (!head_tok.hex_ok)
                    step_err = ERR_BAD_HEX;
                else
                begin
                    accum_next  = accum_shift;
                    digits_next = digits_reg + 1'b1;
                    if (last_digit)
                    begin
                        if (phase_reg == PH_HEX1)
                        begin
                            if (accum_shift[15:10] == SURR_HIGH_TAG)
                                high_next = accum_shift[9:0];
                            else if (accum_shift[15:10] == SURR_LOW_TAG)
                                step_err = ERR_LONE_LOW;
                            else
                                step_data = utf8_pack({5'b0, accum_shift});
                        end
                        else if (accum_shift[15:10] != SURR_LOW_TAG)
                            step_err = ERR_BAD_LOW;
                        else
                            step_data = utf8_pack(pair_cp);
                    end
                end
            end
            PH_NEEDBS:
            begin
                if (head_tok.eod || !head_tok.is_bsl)
                    step_err = ERR_LONE_HIGH;
            end
            PH_NEEDU:
            begin
                if (head_tok.eod || !head_tok.is_u)
                    step_err = ERR_LONE_HIGH;
                else
                begin
                    accum_next  = '0;
                    digits_next = '0;
                end
            end
            default:
            begin
                if (head_tok.eod || !head_tok.is_quote)
                    step_err = ERR_NO_OPEN;
            end
        endcase
        // Drop everything on an error
        if (step_err != ERR_NONE)
        begin
            step_status = ST_ERROR;
            step_data   = '0;
            accum_next  = '0;
            digits_next = '0;
            high_next   = '0;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_BODY:
            begin
                if (head_tok.is_quote)
                    phase_next = PH_IDLE;
                else if (head_tok.is_bsl)
                    phase_next = PH_ESC;
            end
            PH_ESC:
            begin
                phase_next = head_tok.is_u ? PH_HEX1 : PH_BODY;
            end
            PH_HEX1:
            begin
                if (last_digit)
                    phase_next = (accum_shift[15:10] == SURR_HIGH_TAG) ? PH_NEEDBS : PH_BODY;
            end
            PH_HEX2:
            begin
                if (last_digit)
                    phase_next = PH_BODY;
            end
            PH_NEEDBS: phase_next = PH_NEEDU;
            PH_NEEDU:  phase_next = PH_HEX2;
            default:   phase_next = PH_BODY;
        endcase
        if (step_err != ERR_NONE)
            phase_next = PH_IDLE;
    end

    // Decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            accum_reg  <= '0;
            digits_reg <= '0;
            high_reg   <= '0;
        end
        else if (pop)
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
            high_reg   <= high_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_bytes_reg <= step_data.bytes;
            out_count_reg <= step_data.count;
            status_reg    <= step_status;
            err_reg       <= step_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bytes  = out_bytes_reg;
    assign out_count  = out_count_reg;
    assign status     = status_reg;
    assign error_code = err_reg;

    `ASSERT_CLK(a_err_matches_status, clk, rst_n,
                out_valid_reg |-> ((status_reg == ST_ERROR) == (err_reg != ERR_NONE)))
    `ASSERT_NEVER(a_empty_result_zero, clk, rst_n,
                  out_valid_reg && (out_count_reg == 3'd0) && (out_bytes_reg != 32'h0))
    `ASSERT_CLK(a_error_to_idle, clk, rst_n,
                (pop && (step_err != ERR_NONE)) |=> (phase_reg == PH_IDLE))

endmodule
